// File: src/tphc_pkg.sv
package tphc_pkg;

  // Phase of the classifier, one-hot coded
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_MEASURE  = 5'b00100,
    PH_HOLDWAIT = 5'b01000,
    PH_STOPWAIT = 5'b10000
  } phase_e;

  // Gate commands
  localparam logic [1:0] GATE_OPEN  = 2'd0;
  localparam logic [1:0] GATE_CLOSE = 2'd1;
  localparam logic [1:0] GATE_STOP  = 2'd2;

  // Press kinds
  localparam logic [1:0] KIND_TAP     = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TAP      = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] TAP_RST      = 16'd300;
  localparam logic [15:0] LIMIT_RST    = 16'd400;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned FLAGS_W = 4;

  // Security flags are bit 2 (open) and bit 3 (close)
  localparam logic [FLAGS_W-1:0] FLAG_SEC_MASK = 4'b1100;
  localparam logic [CFG_W-1:0]   TIMER_MAX     = 16'hFFFF;

  // Result of one tick
  typedef struct packed {
    logic       valid;
    logic       source_panel;
    logic [1:0] command;
    logic [1:0] press_kind;
  } result_t;

  // Decoded tick item
  typedef struct packed {
    logic [FLAGS_W-1:0] notify_flags;
    logic               drv_open_pressed;
    logic               drv_close_pressed;
    logic               sec_open_pressed;
    logic               sec_close_pressed;
  } tick_t;

endpackage

// File: src/two_panel_tap_hold_classifier_top.sv
// Two-panel tap/hold classifier.
// Output: a result caused by a tick appears on the master side in the cycle after
// the tick transaction, held in the output register until taken.
// Throughput: one tick per cycle unless a held result stalls; the output register
// lets a new tick in while the previous result is taken in the same cycle.
// Reset: asynchronous, active low; clears phase, flags, timer and output valid,
// and loads the configuration registers with 20, 300 and 400 ticks.
module two_panel_tap_hold_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] notify_flags, [4] drv_open_pressed, [5] drv_close_pressed,
  // [6] sec_open_pressed, [7] sec_close_pressed
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] source_panel, [2:1] command, [4:3] press_kind, [7:5] zero
  output logic [7:0]  m_axis_tdata
);
  import tphc_pkg::*;

  tick_t      tick;
  result_t    res;
  logic       accept;
  logic       out_valid_q, out_valid_d;
  logic [4:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tick.notify_flags      = s_axis_tdata[3:0];
  assign tick.drv_open_pressed  = s_axis_tdata[4];
  assign tick.drv_close_pressed = s_axis_tdata[5];
  assign tick.sec_open_pressed  = s_axis_tdata[6];
  assign tick.sec_close_pressed = s_axis_tdata[7];

  tphc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .tick_accept_i (accept),
    .tick_i        (tick),
    .result_o      (res)
  );

  // Load a new result or drop the one taken
  assign out_valid_d = accept ? res.valid : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_data_q <= {res.press_kind, res.command, res.source_panel};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_data_q};

endmodule

// File: src/tphc_core.sv
module tphc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  tick_accept_i,
  input  tphc_pkg::tick_t       tick_i,
  output tphc_pkg::result_t     result_o
);
  import tphc_pkg::*;

  logic [CFG_W-1:0]   debounce_q, tap_q, limit_q;
  phase_e             phase_q, phase_d;
  logic [FLAGS_W-1:0] pending_q, pending_d, pending_or;
  logic [CFG_W-1:0]   timer_q, timer_d, timer_inc;
  logic               panel_q, panel_d;
  logic [1:0]         held_cmd_q, held_cmd_d;
  logic               open_lv, close_lv, held_lv;
  result_t            res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      tap_q      <= TAP_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_TAP:      tap_q      <= cfg_data_i;
        REG_LIMIT:    limit_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Select the levels of the served panel
  assign open_lv    = panel_q ? tick_i.sec_open_pressed  : tick_i.drv_open_pressed;
  assign close_lv   = panel_q ? tick_i.sec_close_pressed : tick_i.drv_close_pressed;
  assign held_lv    = (held_cmd_q == GATE_CLOSE) ? close_lv : open_lv;
  assign pending_or = pending_q | tick_i.notify_flags;
  assign timer_inc  = (timer_q != TIMER_MAX) ? timer_q + 16'd1 : timer_q;

  // Advance the phase for one tick
  always_comb begin
    phase_d    = phase_q;
    pending_d  = pending_or;
    timer_d    = timer_q;
    panel_d    = panel_q;
    held_cmd_d = held_cmd_q;
    res        = '0;
    res.source_panel = panel_q;
    case (phase_q)
      PH_DEBOUNCE: begin
        timer_d = timer_inc;
        if (timer_inc >= debounce_q) begin
          if (open_lv && close_lv) begin
            phase_d        = PH_STOPWAIT;
            res.valid      = 1'b1;
            res.command    = GATE_STOP;
            res.press_kind = KIND_HOLD;
          end else if (open_lv || close_lv) begin
            held_cmd_d = open_lv ? GATE_OPEN : GATE_CLOSE;
            timer_d    = '0;
            phase_d    = PH_MEASURE;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_MEASURE: begin
        timer_d = timer_inc;
        if (!held_lv || timer_inc >= limit_q) begin
          res.valid   = 1'b1;
          res.command = held_cmd_q;
          if (timer_inc >= tap_q) begin
            phase_d        = PH_HOLDWAIT;
            res.press_kind = KIND_HOLD;
          end else begin
            phase_d        = PH_IDLE;
            res.press_kind = KIND_TAP;
          end
        end
      end
      PH_HOLDWAIT: begin
        if (!held_lv) begin
          phase_d        = PH_IDLE;
          res.valid      = 1'b1;
          res.command    = held_cmd_q;
          res.press_kind = KIND_RELEASE;
        end
      end
      PH_STOPWAIT: begin
        if (!open_lv && !close_lv) phase_d = PH_IDLE;
      end
      default: begin
        // Idle: start a notification when flags are pending
        phase_d = PH_IDLE;
        if (pending_or != '0) begin
          panel_d   = (pending_or & FLAG_SEC_MASK) != '0;
          pending_d = '0;
          timer_d   = '0;
          phase_d   = PH_DEBOUNCE;
        end
      end
    endcase
  end

  // Update state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pending_q  <= '0;
      timer_q    <= '0;
      panel_q    <= 1'b0;
      held_cmd_q <= GATE_OPEN;
    end else if (tick_accept_i) begin
      phase_q    <= phase_d;
      pending_q  <= pending_d;
      timer_q    <= timer_d;
      panel_q    <= panel_d;
      held_cmd_q <= held_cmd_d;
    end
  end

  assign result_o = res;

endmodule

// File: src/tphc_checker.sv
module tphc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Input side is free whenever the output register can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("tick stalled while output register is free");

  // A new result needs a tick transaction in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready))
      |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without a tick transaction");

  // Command and kind codes stay in range, padding stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3) && (m_axis_tdata[4:3] != 2'd3)
                      && (m_axis_tdata[7:5] == 3'd0))
    else $error("result code out of range");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind two_panel_tap_hold_classifier_top tphc_checker u_tphc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
